### rtl/htsf_pkg.sv
// ----------------------------------------------------------------------------
// htsf_pkg
// Types, constants and helper functions for the html to text stream filter.
// ----------------------------------------------------------------------------
package htsf_pkg;

    localparam int NAME_MAX = 16;
    localparam int MAX_OUT  = 16;

    localparam logic [1:0] SUP_STYLE  = 2'h1;
    localparam logic [1:0] SUP_SCRIPT = 2'h2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_final;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_ENT,
        S_NUM,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        SCAN_TEXT,
        SCAN_TAG,
        SCAN_ENT
    } t_scan;

    typedef enum logic [1:0] {
        SRC_CHAR,
        SRC_STR,
        SRC_ECHO
    } t_src;

    typedef enum logic [2:0] {
        STR_HR,
        STR_LI,
        STR_COPY,
        STR_REG,
        STR_TRADE,
        STR_HELLIP
    } t_str;

    typedef struct packed {
        logic idle;
        logic load;
        logic step;
        logic ent;
        logic num;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic step_ent;
        logic step_emit;
        logic ent_num;
        logic ent_emit;
        logic num_done;
        logic emit_last;
    } t_sts;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5a)) ? (c + 8'h20) : c;
    endfunction

    // head holds the first eight name bytes, entry 0 in the low byte;
    // str holds the literal right aligned
    function automatic logic name_is(input logic [63:0] head, input int unsigned len,
                                     input logic [63:0] str, input int unsigned n);
        logic        ok;
        int unsigned idx;
        ok = (len == n);
        for (int unsigned i = 0; i < 8; i++) begin
            idx = (i < n) ? (n - 1 - i) : 0;
            if ((i < n) && (head[8*i +: 8] != str[8*idx +: 8])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic [63:0] str_text(input t_str id);
        case (id)
            STR_HR:     return 64'("\n\t---\n\t");
            STR_LI:     return 64'("\n\t* ");
            STR_COPY:   return 64'("(C)");
            STR_REG:    return 64'("(R)");
            STR_TRADE:  return 64'("(TM)");
            STR_HELLIP: return 64'("...");
            default:    return 64'h0;
        endcase
    endfunction

    function automatic logic [3:0] str_len(input t_str id);
        case (id)
            STR_HR:     return 4'd7;
            STR_LI:     return 4'd4;
            STR_COPY:   return 4'd3;
            STR_REG:    return 4'd3;
            STR_TRADE:  return 4'd4;
            STR_HELLIP: return 4'd3;
            default:    return 4'd1;
        endcase
    endfunction

    function automatic logic [7:0] str_byte(input t_str id, input logic [2:0] k);
        logic [63:0] s;
        int unsigned n;
        int unsigned idx;
        s   = str_text(id);
        n   = 32'(str_len(id));
        idx = (32'(k) < n) ? (n - 1 - 32'(k)) : 0;
        return s[8*idx +: 8];
    endfunction

endpackage

### rtl/htsf_ctrl.sv
// ----------------------------------------------------------------------------
// htsf_ctrl
// Sequencer: accept, step, entity decode, numeric parse and emit phases.
// ----------------------------------------------------------------------------
module htsf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  htsf_pkg::t_sts  i_sts,
    output htsf_pkg::t_cmd  o_cmd
);

    htsf_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= htsf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            htsf_pkg::S_IDLE: begin
                if (i_in_valid) n_state = htsf_pkg::S_STEP;
            end
            htsf_pkg::S_STEP: begin
                if (i_sts.step_ent)       n_state = htsf_pkg::S_ENT;
                else if (i_sts.step_emit) n_state = htsf_pkg::S_EMIT;
                else                      n_state = htsf_pkg::S_IDLE;
            end
            htsf_pkg::S_ENT: begin
                if (i_sts.ent_num)       n_state = htsf_pkg::S_NUM;
                else if (i_sts.ent_emit) n_state = htsf_pkg::S_EMIT;
                else                     n_state = htsf_pkg::S_IDLE;
            end
            htsf_pkg::S_NUM: begin
                if (i_sts.num_done) n_state = htsf_pkg::S_EMIT;
            end
            htsf_pkg::S_EMIT: begin
                if (i_sts.emit_last) n_state = htsf_pkg::S_IDLE;
            end
            default: n_state = htsf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.idle = (r_state == htsf_pkg::S_IDLE);
        o_cmd.load = (r_state == htsf_pkg::S_IDLE) && i_in_valid;
        o_cmd.step = (r_state == htsf_pkg::S_STEP);
        o_cmd.ent  = (r_state == htsf_pkg::S_ENT);
        o_cmd.num  = (r_state == htsf_pkg::S_NUM);
        o_cmd.emit = (r_state == htsf_pkg::S_EMIT);
    end

endmodule

### rtl/htsf_dp.sv
// ----------------------------------------------------------------------------
// htsf_dp
// Datapath: scan state, name buffer, entity and tag decode, output register.
// ----------------------------------------------------------------------------
module htsf_dp #(
    parameter int NAME_MAX = htsf_pkg::NAME_MAX
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  htsf_pkg::t_cmd  i_cmd,
    input  htsf_pkg::t_in   i_in_data,
    input  logic            i_out_stall,
    output htsf_pkg::t_sts  o_sts,
    output logic            o_out_valid,
    output htsf_pkg::t_out  o_out_data
);

    localparam int LW = $clog2(NAME_MAX + 1);
    localparam int IW = $clog2(NAME_MAX);

    htsf_pkg::t_in   r_in;
    htsf_pkg::t_scan r_scan, n_scan;
    logic [7:0]      r_buf [NAME_MAX];
    logic [LW-1:0]   r_len, n_len;
    logic            r_pws, n_pws;
    logic            r_pre, n_pre;
    logic [1:0]      r_sup, n_sup;
    logic            r_started, n_started;
    htsf_pkg::t_src  r_src, n_src;
    htsf_pkg::t_str  r_str, n_str;
    logic [7:0]      r_char, n_char;
    logic [7:0]      r_code, n_code;
    logic [LW-1:0]   r_cnt, n_cnt;
    logic [LW-1:0]   r_elen, n_elen;
    logic            r_ov, n_ov;
    htsf_pkg::t_out  r_out, n_out;

    logic            w_wr_en;
    logic [7:0]      w_wr_data;
    logic [63:0]     w_head;
    logic [7:0]      w_rd;
    logic [7:0]      w_byte;
    int unsigned     w_len;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_head[8*i +: 8] = r_buf[i];
        end
    end

    assign w_len = 32'(r_len);
    assign w_rd  = r_buf[r_cnt[IW-1:0]];

    always_comb begin
        case (r_src)
            htsf_pkg::SRC_STR:  w_byte = htsf_pkg::str_byte(r_str, r_cnt[2:0]);
            htsf_pkg::SRC_ECHO: w_byte = w_rd;
            default:            w_byte = r_char;
        endcase
    end

    always_comb begin
        logic [7:0] c;
        logic       fin_ent;
        logic       hn;
        logic       ehn;
        n_scan    = r_scan;
        n_len     = r_len;
        n_pws     = r_pws;
        n_pre     = r_pre;
        n_sup     = r_sup;
        n_started = r_started;
        n_src     = r_src;
        n_str     = r_str;
        n_char    = r_char;
        n_code    = r_code;
        n_cnt     = r_cnt;
        n_elen    = r_elen;
        n_ov      = r_ov;
        n_out     = r_out;
        w_wr_en   = 1'b0;
        w_wr_data = htsf_pkg::to_lower(r_in.in_byte);
        o_sts     = '0;
        c         = r_in.in_byte;
        fin_ent   = 1'b0;
        hn  = htsf_pkg::name_is(w_head, w_len, {w_head[63:16], 8'h68, w_head[15:8]}, 2)
              && htsf_pkg::is_digit(r_buf[1]) && (r_buf[0] == 8'h68);
        ehn = (w_len == 3) && (r_buf[0] == 8'h2f) && (r_buf[1] == 8'h68)
              && htsf_pkg::is_digit(r_buf[2]);

        if (i_cmd.step) begin
            case (r_scan)
                htsf_pkg::SCAN_TAG: begin
                    if (c == 8'h3e) begin
                        n_scan = htsf_pkg::SCAN_TEXT;
                        if (htsf_pkg::name_is(w_head, w_len, 64'("style"), 5)) begin
                            n_sup = r_sup | htsf_pkg::SUP_STYLE;
                        end else if (htsf_pkg::name_is(w_head, w_len, 64'("script"), 6)) begin
                            n_sup = r_sup | htsf_pkg::SUP_SCRIPT;
                        end else if (htsf_pkg::name_is(w_head, w_len, 64'("/pre"), 4) ||
                                     htsf_pkg::name_is(w_head, w_len, 64'("/xmp"), 4)) begin
                            n_pre = 1'b0;
                        end else if (r_sup == 2'b00) begin
                            if (htsf_pkg::name_is(w_head, w_len, 64'("pre"), 3) ||
                                htsf_pkg::name_is(w_head, w_len, 64'("xmp"), 3)) begin
                                n_pre = 1'b1;
                            end else if (r_started) begin
                                n_cnt = '0;
                                if (htsf_pkg::name_is(w_head, w_len, 64'("hr"), 2)) begin
                                    n_src  = htsf_pkg::SRC_STR;
                                    n_str  = htsf_pkg::STR_HR;
                                    n_elen = LW'(htsf_pkg::str_len(htsf_pkg::STR_HR));
                                    o_sts.step_emit = 1'b1;
                                end else if (htsf_pkg::name_is(w_head, w_len, 64'("li"), 2)) begin
                                    n_src  = htsf_pkg::SRC_STR;
                                    n_str  = htsf_pkg::STR_LI;
                                    n_elen = LW'(htsf_pkg::str_len(htsf_pkg::STR_LI));
                                    o_sts.step_emit = 1'b1;
                                end else if (htsf_pkg::name_is(w_head, w_len, 64'("p"), 1) ||
                                             htsf_pkg::name_is(w_head, w_len, 64'("div"), 3) ||
                                             htsf_pkg::name_is(w_head, w_len, 64'("br"), 2) ||
                                             htsf_pkg::name_is(w_head, w_len, 64'("dd"), 2) ||
                                             htsf_pkg::name_is(w_head, w_len, 64'("dt"), 2) ||
                                             htsf_pkg::name_is(w_head, w_len, 64'("ul"), 2) ||
                                             hn || ehn) begin
                                    n_src  = htsf_pkg::SRC_CHAR;
                                    n_char = 8'h0a;
                                    n_elen = LW'(1);
                                    o_sts.step_emit = 1'b1;
                                end
                            end
                        end else begin
                            if (htsf_pkg::name_is(w_head, w_len, 64'("/style"), 6)) begin
                                n_sup = r_sup & ~htsf_pkg::SUP_STYLE;
                            end else if (htsf_pkg::name_is(w_head, w_len, 64'("/script"), 7)) begin
                                n_sup = r_sup & ~htsf_pkg::SUP_SCRIPT;
                            end
                        end
                    end else if (w_len < NAME_MAX) begin
                        w_wr_en = 1'b1;
                        n_len   = r_len + LW'(1);
                    end
                end
                htsf_pkg::SCAN_ENT: begin
                    if (c == 8'h3b) begin
                        fin_ent = 1'b1;
                    end else begin
                        if (w_len < NAME_MAX) begin
                            w_wr_en = 1'b1;
                            n_len   = r_len + LW'(1);
                        end
                        if (w_len >= NAME_MAX - 1) fin_ent = 1'b1;
                    end
                end
                default: begin
                    if (c == 8'h0d) begin
                        // carriage return dropped
                    end else if (c == 8'h0a) begin
                        if (r_pre) begin
                            n_char = 8'h0a;
                            o_sts.step_emit = 1'b1;
                        end else if (!r_pws) begin
                            n_char = 8'h20;
                            n_pws  = 1'b1;
                            o_sts.step_emit = 1'b1;
                        end
                    end else if (c == 8'h3c) begin
                        n_scan = htsf_pkg::SCAN_TAG;
                        n_len  = '0;
                    end else if (r_sup != 2'b00) begin
                        // suppressed inside style or script
                    end else if (c == 8'h26) begin
                        n_scan = htsf_pkg::SCAN_ENT;
                        n_len  = '0;
                    end else if (!r_pws || (c != 8'h20) || r_pre) begin
                        n_pws  = (c == 8'h20);
                        n_char = c;
                        o_sts.step_emit = 1'b1;
                    end
                    if (o_sts.step_emit) begin
                        n_src  = htsf_pkg::SRC_CHAR;
                        n_elen = LW'(1);
                        n_cnt  = '0;
                    end
                end
            endcase
            if (r_in.in_final && (n_scan == htsf_pkg::SCAN_ENT)) fin_ent = 1'b1;
            if (r_in.in_final || fin_ent) n_scan = htsf_pkg::SCAN_TEXT;
            if (o_sts.step_emit) n_started = 1'b1;
            o_sts.step_ent = fin_ent;
        end

        if (i_cmd.ent) begin
            n_cnt = '0;
            if ((w_len > 0) && (r_buf[0] == 8'h23)) begin
                n_code = '0;
                n_cnt  = LW'(1);
                o_sts.ent_num = 1'b1;
            end else begin
                n_pws = 1'b0;
                o_sts.ent_emit = 1'b1;
                n_src  = htsf_pkg::SRC_CHAR;
                n_elen = LW'(1);
                if (htsf_pkg::name_is(w_head, w_len, 64'("nbsp"), 4)) begin
                    n_char = 8'h20;
                end else if (htsf_pkg::name_is(w_head, w_len, 64'("quot"), 4) ||
                             htsf_pkg::name_is(w_head, w_len, 64'("laquo"), 5) ||
                             htsf_pkg::name_is(w_head, w_len, 64'("raquo"), 5) ||
                             htsf_pkg::name_is(w_head, w_len, 64'("ldquo"), 5) ||
                             htsf_pkg::name_is(w_head, w_len, 64'("rdquo"), 5) ||
                             htsf_pkg::name_is(w_head, w_len, 64'("bdquo"), 5)) begin
                    n_char = 8'h22;
                end else if (htsf_pkg::name_is(w_head, w_len, 64'("lt"), 2)) begin
                    n_char = 8'h3c;
                end else if (htsf_pkg::name_is(w_head, w_len, 64'("gt"), 2)) begin
                    n_char = 8'h3e;
                end else if (htsf_pkg::name_is(w_head, w_len, 64'("ndash"), 5) ||
                             htsf_pkg::name_is(w_head, w_len, 64'("mdash"), 5)) begin
                    n_char = 8'h5f;
                end else if (htsf_pkg::name_is(w_head, w_len, 64'("copy"), 4)) begin
                    n_src  = htsf_pkg::SRC_STR;
                    n_str  = htsf_pkg::STR_COPY;
                    n_elen = LW'(htsf_pkg::str_len(htsf_pkg::STR_COPY));
                end else if (htsf_pkg::name_is(w_head, w_len, 64'("reg"), 3)) begin
                    n_src  = htsf_pkg::SRC_STR;
                    n_str  = htsf_pkg::STR_REG;
                    n_elen = LW'(htsf_pkg::str_len(htsf_pkg::STR_REG));
                end else if (htsf_pkg::name_is(w_head, w_len, 64'("trade"), 5)) begin
                    n_src  = htsf_pkg::SRC_STR;
                    n_str  = htsf_pkg::STR_TRADE;
                    n_elen = LW'(htsf_pkg::str_len(htsf_pkg::STR_TRADE));
                end else if (htsf_pkg::name_is(w_head, w_len, 64'("hellip"), 6)) begin
                    n_src  = htsf_pkg::SRC_STR;
                    n_str  = htsf_pkg::STR_HELLIP;
                    n_elen = LW'(htsf_pkg::str_len(htsf_pkg::STR_HELLIP));
                end else if (htsf_pkg::name_is(w_head, w_len, 64'("times"), 5)) begin
                    n_char = 8'h78;
                end else if (htsf_pkg::name_is(w_head, w_len, 64'("divide"), 6)) begin
                    n_char = 8'h3a;
                end else if (htsf_pkg::name_is(w_head, w_len, 64'("amp"), 3)) begin
                    n_char = 8'h26;
                end else if (w_len != 0) begin
                    // unknown name echoed, capped at the burst limit
                    n_src  = htsf_pkg::SRC_ECHO;
                    n_elen = (w_len < htsf_pkg::MAX_OUT) ? r_len : LW'(htsf_pkg::MAX_OUT);
                end else begin
                    o_sts.ent_emit = 1'b0;
                end
                if (o_sts.ent_emit) n_started = 1'b1;
            end
        end

        if (i_cmd.num) begin
            if ((32'(r_cnt) < w_len) && htsf_pkg::is_digit(w_rd)) begin
                n_code = 8'(r_code * 8'd10 + (w_rd - 8'h30));
                n_cnt  = r_cnt + LW'(1);
            end else begin
                n_src     = htsf_pkg::SRC_CHAR;
                n_char    = r_code;
                n_elen    = LW'(1);
                n_cnt     = '0;
                n_pws     = (r_code == 8'h20);
                n_started = 1'b1;
                o_sts.num_done = 1'b1;
            end
        end

        if (r_ov && !i_out_stall) n_ov = 1'b0;
        if (i_cmd.emit && (!r_ov || !i_out_stall)) begin
            n_ov           = 1'b1;
            n_out.out_byte = w_byte;
            n_out.out_last = (r_cnt == r_elen - LW'(1));
            n_cnt          = r_cnt + LW'(1);
            o_sts.emit_last = n_out.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan    <= htsf_pkg::SCAN_TEXT;
            r_len     <= '0;
            r_pws     <= 1'b1;
            r_pre     <= 1'b0;
            r_sup     <= 2'b00;
            r_started <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_scan    <= n_scan;
            r_len     <= n_len;
            r_pws     <= n_pws;
            r_pre     <= n_pre;
            r_sup     <= n_sup;
            r_started <= n_started;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in_data;
        if (w_wr_en) r_buf[r_len[IW-1:0]] <= w_wr_data;
        r_src  <= n_src;
        r_str  <= n_str;
        r_char <= n_char;
        r_code <= n_code;
        r_cnt  <= n_cnt;
        r_elen <= n_elen;
        r_out  <= n_out;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

### rtl/html_to_text_stream_filter.sv
// ----------------------------------------------------------------------------
// html_to_text_stream_filter
// Html byte stream in, plain text bytes out, one request at a time.
// ----------------------------------------------------------------------------
// flow: a request is loaded in idle and stepped; text to output then goes to emit,
//   named entities pass entity decode first, numeric entities also numeric parse
//   of their digits; the next request is taken only when the sequencer is idle;
//   the sequencer emits one byte per cycle from a single output register unless stalled
// reset: synchronous active low; resets scan mode and flags, clears output valid
module html_to_text_stream_filter #(
    parameter int NAME_MAX = htsf_pkg::NAME_MAX
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  htsf_pkg::t_in   i_in_data,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output htsf_pkg::t_out  o_out_data,
    input  logic            i_out_stall
);

    htsf_pkg::t_cmd w_cmd;
    htsf_pkg::t_sts w_sts;

    htsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    htsf_dp #(
        .NAME_MAX (NAME_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_stall = !w_cmd.idle;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("accepted request did not block the next one");

    a_load_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> w_cmd.step)
        else $error("step did not follow load");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.emit_last |=> !w_cmd.emit && w_cmd.idle)
        else $error("emission continued after last byte");

endmodule

### test/htsf_checker.sv
// ----------------------------------------------------------------------------
// htsf_checker
// Watches both channels of the html to text stream filter, works out the text
// bytes each accepted html byte should produce and compares them in order.
// ----------------------------------------------------------------------------
module htsf_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  htsf_pkg::t_in  i_in_data,
    input  logic           i_in_stall,
    input  logic           i_out_valid,
    input  htsf_pkg::t_out i_out_data,
    input  logic           i_out_stall,
    output int             o_errors,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    htsf_pkg::t_out  text_q[$];
    htsf_pkg::t_scan mode;
    logic [7:0]      nbuf[htsf_pkg::NAME_MAX];
    int              nlen;
    logic            prev_space;
    logic            pre_mode;
    logic [1:0]      sup;
    logic            started;
    logic [7:0]      burst[$];

    assign o_pending = text_q.size();

    function automatic logic [7:0] lc(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic name_eq(input string s);
        if (s.len() != nlen) return 1'b0;
        for (int i = 0; i < nlen; i++) if (nbuf[i] != s[i]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic emit(input string s);
        for (int i = 0; i < s.len(); i++) begin
            if (burst.size() < htsf_pkg::MAX_OUT) burst.push_back(s[i]);
            started = 1'b1;
        end
    endtask

    task automatic emit_byte(input logic [7:0] c);
        if (burst.size() < htsf_pkg::MAX_OUT) burst.push_back(c);
        started = 1'b1;
    endtask

    task automatic close_tag();
        logic hn;
        hn = (nlen == 2 && nbuf[0] == "h" && dig(nbuf[1])) ||
             (nlen == 3 && nbuf[0] == "/" && nbuf[1] == "h" && dig(nbuf[2]));
        if (name_eq("style")) sup |= htsf_pkg::SUP_STYLE;
        else if (name_eq("script")) sup |= htsf_pkg::SUP_SCRIPT;
        else if (name_eq("/pre") || name_eq("/xmp")) pre_mode = 1'b0;
        else if (sup == 2'b00) begin
            if (name_eq("pre") || name_eq("xmp")) pre_mode = 1'b1;
            else if (started) begin
                if (name_eq("hr")) emit("\n\t---\n\t");
                else if (name_eq("li")) emit("\n\t* ");
                else if (name_eq("p") || name_eq("div") || name_eq("br") ||
                         name_eq("dd") || name_eq("dt") || name_eq("ul") || hn)
                    emit("\n");
            end
        end else begin
            if (name_eq("/style")) sup &= ~htsf_pkg::SUP_STYLE;
            else if (name_eq("/script")) sup &= ~htsf_pkg::SUP_SCRIPT;
        end
        mode = htsf_pkg::SCAN_TEXT;
    endtask

    task automatic close_entity();
        logic [7:0] code;
        mode = htsf_pkg::SCAN_TEXT;
        if (nlen > 0 && nbuf[0] == "#") begin
            code = 8'd0;
            for (int i = 1; i < nlen && dig(nbuf[i]); i++)
                code = code * 8'd10 + (nbuf[i] - "0");
            emit_byte(code);
            prev_space = (code == 8'd32);
            return;
        end
        prev_space = 1'b0;
        if (name_eq("nbsp")) emit(" ");
        else if (name_eq("quot") || name_eq("laquo") || name_eq("raquo") ||
                 name_eq("ldquo") || name_eq("rdquo") || name_eq("bdquo")) emit("\"");
        else if (name_eq("lt")) emit("<");
        else if (name_eq("gt")) emit(">");
        else if (name_eq("ndash") || name_eq("mdash")) emit("_");
        else if (name_eq("copy")) emit("(C)");
        else if (name_eq("reg")) emit("(R)");
        else if (name_eq("trade")) emit("(TM)");
        else if (name_eq("hellip")) emit("...");
        else if (name_eq("times")) emit("x");
        else if (name_eq("divide")) emit(":");
        else if (name_eq("amp")) emit("&");
        else for (int i = 0; i < nlen && i < htsf_pkg::MAX_OUT; i++) emit_byte(nbuf[i]);
    endtask

    task automatic predict(input htsf_pkg::t_in req);
        logic [7:0]     c;
        htsf_pkg::t_out r;
        c = req.in_byte;
        burst.delete();
        if (mode == htsf_pkg::SCAN_TAG) begin
            if (c == ">") close_tag();
            else if (nlen < htsf_pkg::NAME_MAX) begin nbuf[nlen] = lc(c); nlen++; end
        end else if (mode == htsf_pkg::SCAN_ENT) begin
            if (c == ";") close_entity();
            else begin
                if (nlen < htsf_pkg::NAME_MAX) begin nbuf[nlen] = lc(c); nlen++; end
                if (nlen >= htsf_pkg::NAME_MAX) close_entity();
            end
        end else begin
            if (c == 8'h0d) begin
            end else if (c == 8'h0a) begin
                if (pre_mode) emit_byte(8'h0a);
                else if (!prev_space) begin emit(" "); prev_space = 1'b1; end
            end else if (c == "<") begin
                mode = htsf_pkg::SCAN_TAG; nlen = 0;
            end else if (sup != 2'b00) begin
            end else if (c == "&") begin
                mode = htsf_pkg::SCAN_ENT; nlen = 0;
            end else if (!prev_space || c != " " || pre_mode) begin
                prev_space = (c == " ");
                emit_byte(c);
            end
        end
        if (req.in_final) begin
            if (mode == htsf_pkg::SCAN_ENT) close_entity();
            mode = htsf_pkg::SCAN_TEXT;
        end
        foreach (burst[k]) begin
            r.out_byte = burst[k];
            r.out_last = (k == burst.size() - 1);
            text_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        htsf_pkg::t_out want;
        if (!i_rst_n) begin
            mode = htsf_pkg::SCAN_TEXT; nlen = 0; prev_space = 1'b1; pre_mode = 1'b0;
            sup = 2'b00; started = 1'b0; text_q.delete(); o_errors = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (text_q.size() == 0) begin
                    $display("%0t: unexpected output byte %h last %b", $time,
                             i_out_data.out_byte, i_out_data.out_last);
                    o_errors++;
                end else begin
                    want = text_q.pop_front();
                    if (want.out_byte != i_out_data.out_byte ||
                        want.out_last != i_out_data.out_last) begin
                        $display("%0t: expected byte %h last %b, got byte %h last %b",
                                 $time, want.out_byte, want.out_last,
                                 i_out_data.out_byte, i_out_data.out_last);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict(i_in_data);
        end
    end
endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives html fragments, entities, tags and random bytes into the filter with
// bursty requests and a stalling receiver; the checker compares the text.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 400000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           in_valid = 1'b0;
    htsf_pkg::t_in  in_data = '0;
    logic           in_stall;
    logic           out_valid;
    htsf_pkg::t_out out_data;
    logic           out_stall = 1'b0;
    int             errors;
    int             pending;
    int             cycles = 0;
    int             gap_left = 0;

    always #1 i_clk = ~i_clk;

    html_to_text_stream_filter u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_valid), .i_in_data(in_data),
        .o_in_stall(in_stall), .o_out_valid(out_valid), .o_out_data(out_data),
        .i_out_stall(out_stall)
    );

    htsf_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_valid), .i_in_data(in_data),
        .i_in_stall(in_stall), .i_out_valid(out_valid), .i_out_data(out_data),
        .i_out_stall(out_stall), .o_errors(errors), .o_pending(pending)
    );

    // receiver stall: alternating quiet and busy stretches
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 200;
        if (stall_phase < 60) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 2) == 0);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** html_to_text_stream_filter: FAILED **");
            $finish;
        end
    end

    // one request, held until accepted; gaps between bursts
    task automatic send(input logic [7:0] b, input logic fin = 1'b0);
        if (gap_left == 0 && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 6);
        while (gap_left > 0) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            gap_left--;
        end
        in_valid <= 1'b1;
        in_data  <= '{in_byte: b, in_final: fin};
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) send(s[i]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    string frags[] = '{"<p>", "<br>", "<hr>", "<li>", "<div>", "<h3>", "</h7>", "<ul>",
                       "<dd>", "<dt>", "<pre>", "</pre>", "<XMP>", "</xmp>", "<style>",
                       "</style>", "<script>", "</script>", "&nbsp;", "&quot;", "&lt;",
                       "&gt;", "&mdash;", "&copy;", "&reg;", "&trade;", "&hellip;",
                       "&times;", "&divide;", "&amp;", "&#65;", "&#300;", "&#32;",
                       "&#x41;", "&#;", "&Foo;", "&;", "&laquo;", "&ndash;",
                       "Hello World", "a  b", "x\r\ny", "\n\n", " ", "<A HREF=x>"};

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed
        send_str("<p>Hi<p>");
        send_str("A\r\n  B<br><hr><li>");
        send_str("&copy;&#65;&#300;&#x41;&zz;");
        send_str("&abcdefghijklmnopqrs");
        send("&"); send("q", 1'b1);
        send_str("<style>x</pre><pre>\n\n</style>");
        send_str("</pre><verylongtagnameabcdefghij>");
        send("<"); send(8'hff, 1'b1);
        send(8'h00); send(8'hff); send(8'h80); send(8'h7f);
        drain();
        // random: well-formed fragments mostly, noise sometimes
        for (int n = 0; n < 6; n++) begin
            if ($urandom_range(0, 3) != 0) send_str(frags[$urandom_range(0, frags.size()-1)]);
            else send(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            if (n == 3) drain();
        end
        send(" ", 1'b1);
        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0) $display("** html_to_text_stream_filter: PASSED **");
        else $display("** html_to_text_stream_filter: FAILED **");
        $finish;
    end
endmodule
